// ----- hdl/h4d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package h4d_pkg;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_ACL   = 2'd1,
    KIND_SCO   = 2'd2,
    KIND_ISO   = 2'd3
  } kind_e;

  localparam logic [7:0] TYPE_ACL   = 8'h02;
  localparam logic [7:0] TYPE_SCO   = 8'h03;
  localparam logic [7:0] TYPE_EVENT = 8'h04;
  localparam logic [7:0] TYPE_ISO   = 8'h05;

  localparam logic [2:0] HDR_LEN_EVENT = 3'd2;
  localparam logic [2:0] HDR_LEN_ACL   = 3'd4;
  localparam logic [2:0] HDR_LEN_SCO   = 3'd3;
  localparam logic [2:0] HDR_LEN_ISO   = 3'd4;

  localparam logic [2:0] HDR_IDX_LEN_LO = 3'd2;

  typedef struct packed {
    logic       aborted;
    logic       dropped_type;
    logic       last_of_packet;
    logic       first_of_packet;
    logic       is_header;
    kind_e      packet_kind;
    logic [7:0] out_byte;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/h4_packet_deframer.sv -----
// Channel  Dir  tdata                 tuser                                   tlast
// s_axis   in   data_byte[7:0]        action[0]                               -
// m_axis   out  out_byte[7:0]         packet_kind[1:0], is_header[2],         last_of_packet
//                                     first_of_packet[3], dropped_type[4],
//                                     aborted[5]
//
// One byte can be accepted per cycle while s_axis_tready_o is high; its result, if any, is registered
// into the output register unless m_axis is stalled, in which case it waits in the skid stage.
// Known type bytes and flushes while idle produce no result.
// The output register and a one-item skid stage decouple the two sides, so
// s_axis_tready_o falls only when both hold an item.
// Reset returns the deframer to idle with both output stages empty.
`timescale 1ns / 1ps
`default_nettype none

module h4_packet_deframer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // data_byte[7:0]
  input  wire  [0:0]  s_axis_tuser_i,   // action[0]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_byte[7:0]
  output logic [5:0]  m_axis_tuser_o,   // kind[1:0] hdr[2] first[3] drop[4] abort[5]
  output logic        m_axis_tlast_o
);

  logic                active_q, active_d;
  h4d_pkg::kind_e      kind_q, kind_d;
  logic [7:0]          hdr2_q, hdr2_d;
  logic [2:0]          need_q, need_d;
  logic [2:0]          have_q, have_d;
  logic [15:0]         left_q, left_d;

  logic                accept;
  logic                res_valid;
  h4d_pkg::out_item_t  res;
  h4d_pkg::out_item_t  m_item;
  logic                skid_ready;
  logic [7:0]          b;
  logic [15:0]         len;
  logic [2:0]          have_inc;
  logic [15:0]         left_dec;

  assign s_axis_tready_o = skid_ready;
  assign accept          = s_axis_tvalid_i && skid_ready;
  assign b               = s_axis_tdata_i;
  assign have_inc        = have_q + 3'd1;
  assign left_dec        = left_q - 16'd1;

  always_comb begin
    unique case (kind_q)
      h4d_pkg::KIND_EVENT: len = {8'h00, b};
      h4d_pkg::KIND_SCO:   len = {8'h00, b};
      default:             len = {b, hdr2_q};
    endcase
  end

  always_comb begin
    active_d  = active_q;
    kind_d    = kind_q;
    hdr2_d    = hdr2_q;
    need_d    = need_q;
    have_d    = have_q;
    left_d    = left_q;
    res_valid = 1'b0;
    res       = '0;
    res.out_byte    = b;
    res.packet_kind = kind_q;
    if (s_axis_tuser_i[0]) begin
      if (active_q) begin
        res_valid    = 1'b1;
        res.out_byte = 8'h00;
        res.aborted  = 1'b1;
        active_d     = 1'b0;
        kind_d       = h4d_pkg::KIND_EVENT;
        need_d       = 3'd0;
        have_d       = 3'd0;
        left_d       = 16'd0;
      end
    end else if (!active_q) begin
      have_d = 3'd0;
      left_d = 16'd0;
      unique case (b)
        h4d_pkg::TYPE_EVENT: begin
          active_d = 1'b1;
          kind_d   = h4d_pkg::KIND_EVENT;
          need_d   = h4d_pkg::HDR_LEN_EVENT;
        end
        h4d_pkg::TYPE_ACL: begin
          active_d = 1'b1;
          kind_d   = h4d_pkg::KIND_ACL;
          need_d   = h4d_pkg::HDR_LEN_ACL;
        end
        h4d_pkg::TYPE_SCO: begin
          active_d = 1'b1;
          kind_d   = h4d_pkg::KIND_SCO;
          need_d   = h4d_pkg::HDR_LEN_SCO;
        end
        h4d_pkg::TYPE_ISO: begin
          active_d = 1'b1;
          kind_d   = h4d_pkg::KIND_ISO;
          need_d   = h4d_pkg::HDR_LEN_ISO;
        end
        default: begin
          res_valid        = 1'b1;
          res.packet_kind  = h4d_pkg::KIND_EVENT;
          res.dropped_type = 1'b1;
        end
      endcase
    end else if (have_q < need_q) begin
      res_valid           = 1'b1;
      res.is_header       = 1'b1;
      res.first_of_packet = (have_q == 3'd0);
      have_d              = have_inc;
      if (have_q == h4d_pkg::HDR_IDX_LEN_LO) begin
        hdr2_d = b;
      end
      if (have_inc >= need_q) begin
        left_d = len;
        if (len == 16'd0) begin
          res.last_of_packet = 1'b1;
          active_d           = 1'b0;
          kind_d             = h4d_pkg::KIND_EVENT;
          need_d             = 3'd0;
          have_d             = 3'd0;
        end
      end
    end else begin
      res_valid = 1'b1;
      left_d    = left_dec;
      if (left_dec == 16'd0) begin
        res.last_of_packet = 1'b1;
        active_d           = 1'b0;
        kind_d             = h4d_pkg::KIND_EVENT;
        need_d             = 3'd0;
        have_d             = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      kind_q   <= h4d_pkg::KIND_EVENT;
      need_q   <= 3'd0;
      have_q   <= 3'd0;
      left_q   <= 16'd0;
    end else if (accept) begin
      active_q <= active_d;
      kind_q   <= kind_d;
      need_q   <= need_d;
      have_q   <= have_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdr2_q <= hdr2_d;
    end
  end

  h4d_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .item_i      (res),
    .ready_o     (skid_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_item_o  (m_item),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = m_item.out_byte;
  assign m_axis_tlast_o = m_item.last_of_packet;
  assign m_axis_tuser_o = {m_item.aborted, m_item.dropped_type, m_item.first_of_packet,
                           m_item.is_header, m_item.packet_kind};

`ifndef NO_ASSERTIONS
  a_have_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q <= need_q)
    else $error("Header count ran past the header length.");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (have_q == 3'd0) && (left_q == 16'd0) && (need_q == 3'd0))
    else $error("Idle deframer holds packet state.");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && (need_q != 3'd0) && (have_q == need_q) |-> left_q != 16'd0)
    else $error("Payload phase entered with no bytes left.");
`endif

endmodule

`default_nettype wire

// ----- hdl/h4d_out_skid.sv -----
`timescale 1ns / 1ps
`default_nettype none

module h4d_out_skid (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  h4d_pkg::out_item_t  item_i,
  output logic                ready_o,
  output logic                out_valid_o,
  output h4d_pkg::out_item_t  out_item_o,
  input  wire                 out_ready_i
);

  logic               out_valid_q;
  logic               skid_valid_q;
  h4d_pkg::out_item_t out_q;
  h4d_pkg::out_item_t skid_q;
  logic               load_out;

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign load_out    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_valid_q ? skid_q : item_i;
    end else if (push_i) begin
      skid_q <= item_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid stage holds an item while the output register is empty.");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("An item was pushed while both stages are full.");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i && push_i))
    else $error("Skid stage filled without a stalled output.");

  a_out_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("Output item changed while stalled.");
`endif

endmodule

`default_nettype wire
